@@ rtl/dsf_pkg.sv @@
// Shared constants and word helpers for the deadline slot filler.
package dsf_pkg;

  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int SLOT_IN_W = 11;
  localparam int DUR_W     = 12;
  localparam int HAVE_W    = 13;
  localparam int PC_W      = 6;

  // Number of set bits in one map word.
  function automatic logic [PC_W-1:0] popcount32(input logic [WORD_BITS-1:0] w);
    logic [PC_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      acc = acc + PC_W'(w[i]);
    end
    return acc;
  endfunction

  // Bits at or above the given position.
  function automatic logic [WORD_BITS-1:0] mask_from(input logic [BIT_W-1:0] b);
    return {WORD_BITS{1'b1}} << b;
  endfunction

  // Bits at or below the given position.
  function automatic logic [WORD_BITS-1:0] mask_upto(input logic [BIT_W-1:0] b);
    return {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - b);
  endfunction

endpackage

@@ rtl/dsf_map_mem.sv @@
// Slot map storage: one write port, one read port with registered read data.
module dsf_map_mem
  import dsf_pkg::*;
#(
  parameter int ADDR_W = 6
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic [ADDR_W-1:0]    raddr,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/deadline_slot_filler_unit.sv @@
// Top level of the deadline slot filler: control sequencer around the slot map memory.
//
// Channel   Ports                                            Handshake
// -------   ----------------------------------------------   ---------------------------------
// task in   new_set, start_slot, end_slot, duration          accepted when start & !busy
// result    slots_added, total_running, order_error,         valid for one cycle while done is
//           window_short                                     high; cannot be held off
//
// The slot map lives in a memory of 32-bit words, 2**ADDR_W words deep.
// Each item takes one pass upward over the window's words to count the
// running slots and one pass downward that marks the latest free slots,
// plus up to 32 single-bit steps in the one word where the fill ends.
// An item with new_set first runs a clearing pass over all 2**ADDR_W words
// (64 at the default size); reset runs the same pass, with busy high throughout.
// The result receiver cannot stall; done is high for exactly one cycle per item.
module deadline_slot_filler_unit
  import dsf_pkg::*;
#(
  parameter int TIME_SLOTS = 2048
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 new_set,
  input  logic [SLOT_IN_W-1:0] start_slot,
  input  logic [SLOT_IN_W-1:0] end_slot,
  input  logic [DUR_W-1:0]     duration,
  output logic                 done,
  output logic [DUR_W-1:0]     slots_added,
  output logic [DUR_W-1:0]     total_running,
  output logic                 order_error,
  output logic                 window_short
);

  localparam int SLOT_W   = $clog2(TIME_SLOTS);
  localparam int SLOT_X_W = (SLOT_W > BIT_W + 1) ? SLOT_W : BIT_W + 1;
  localparam int ADDR_W   = SLOT_X_W - BIT_W;
  localparam logic [31:0] MAX_SLOT = 32'(TIME_SLOTS - 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_PREP  = 7'b0000100,
    S_COUNT = 7'b0001000,
    S_CALC  = 7'b0010000,
    S_FILL  = 7'b0100000,
    S_BITS  = 7'b1000000
  } state_t;

  // Done is a separate one-cycle flag so the result stage stays simple.
  state_t                state;
  logic                  result_v;
  logic                  pending;
  logic [ADDR_W-1:0]     clr_addr;
  logic [SLOT_X_W-1:0]   lo;
  logic [SLOT_X_W-1:0]   hi;
  logic [DUR_W-1:0]      need;
  logic [HAVE_W-1:0]     have;
  logic [DUR_W-1:0]      rem;
  logic [DUR_W-1:0]      added;
  logic [DUR_W-1:0]      total;
  logic [SLOT_IN_W-1:0]  prev_end;
  logic                  order_err;
  logic                  short_flag;
  logic [ADDR_W-1:0]     scan_addr;
  logic                  scan_on;
  logic                  dv;
  logic [ADDR_W-1:0]     dw;
  logic [WORD_BITS-1:0]  bw_data;
  logic [WORD_BITS-1:0]  bw_free;
  logic [ADDR_W-1:0]     bw_addr;
  logic [BIT_W-1:0]      bit_idx;

  logic                  accept;
  logic [31:0]           lo_wide;
  logic [31:0]           hi_wide;
  logic [SLOT_X_W-1:0]   lo_c;
  logic [SLOT_X_W-1:0]   hi_c;
  logic                  empty_win;
  logic [ADDR_W-1:0]     lo_word;
  logic [ADDR_W-1:0]     hi_word;
  logic                  rd_issue;
  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [WORD_BITS-1:0]  wdata;
  logic [WORD_BITS-1:0]  rdata;
  logic [WORD_BITS-1:0]  win_mask;
  logic [WORD_BITS-1:0]  free_bits;
  logic [PC_W-1:0]       run_cnt;
  logic [PC_W-1:0]       free_cnt;
  logic [HAVE_W:0]       have_sum;
  logic [HAVE_W-1:0]     have_next;
  logic [HAVE_W-1:0]     need_diff;
  logic [DUR_W-1:0]      rem_calc;
  logic                  word_fits;
  logic [DUR_W-1:0]      rem_after;
  logic                  bit_take;
  logic                  bits_finish;
  logic [WORD_BITS-1:0]  bw_data_next;

  dsf_map_mem #(
    .ADDR_W(ADDR_W)
  ) u_map (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(scan_addr),
    .rdata(rdata)
  );

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE) || result_v;

  // Slots beyond the map saturate to its last slot.
  assign lo_wide = (32'(start_slot) > MAX_SLOT) ? MAX_SLOT : 32'(start_slot);
  assign hi_wide = (32'(end_slot) > MAX_SLOT) ? MAX_SLOT : 32'(end_slot);
  assign lo_c    = lo_wide[SLOT_X_W-1:0];
  assign hi_c    = hi_wide[SLOT_X_W-1:0];

  assign empty_win = lo > hi;
  assign lo_word   = lo[SLOT_X_W-1:BIT_W];
  assign hi_word   = hi[SLOT_X_W-1:BIT_W];

  // A read is issued from the scan address in each cycle of the two passes.
  assign rd_issue = scan_on && ((state == S_COUNT) || (state == S_FILL));

  // Only the window's slots count within the first and last word.
  always_comb begin
    win_mask = {WORD_BITS{1'b1}};
    if (dw == lo_word) begin
      win_mask = win_mask & mask_from(lo[BIT_W-1:0]);
    end
    if (dw == hi_word) begin
      win_mask = win_mask & mask_upto(hi[BIT_W-1:0]);
    end
  end

  assign free_bits = ~rdata & win_mask;
  assign run_cnt   = popcount32(rdata & win_mask);
  assign free_cnt  = popcount32(free_bits);

  // The count only has to reach the duration, so on a 13-bit overflow it clamps to 4096.
  assign have_sum  = {1'b0, have} + (HAVE_W + 1)'(run_cnt);
  assign have_next = have_sum[HAVE_W] ? {1'b1, {(HAVE_W - 1){1'b0}}} : have_sum[HAVE_W-1:0];

  assign need_diff = {1'b0, need} - have;
  assign rem_calc  = ({1'b0, need} > have) ? need_diff[DUR_W-1:0] : '0;

  assign word_fits = DUR_W'(free_cnt) <= rem;
  assign rem_after = rem - DUR_W'(free_cnt);

  // Bit-serial step for the last word, where only some free slots are taken.
  assign bit_take     = bw_free[bit_idx];
  assign bits_finish  = (bit_take && (rem == DUR_W'(1))) || (bit_idx == '0);
  assign bw_data_next = bit_take ? (bw_data | (WORD_BITS'(1) << bit_idx)) : bw_data;

  always_comb begin
    we    = 1'b0;
    waddr = clr_addr;
    wdata = '0;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
      end
      S_FILL: begin
        we    = dv && word_fits;
        waddr = dw;
        wdata = rdata | free_bits;
      end
      S_BITS: begin
        we    = bits_finish;
        waddr = bw_addr;
        wdata = bw_data_next;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    dw <= scan_addr;
    if (rst) begin
      dv <= 1'b0;
    end else begin
      dv <= rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      result_v   <= 1'b0;
      pending    <= 1'b0;
      clr_addr   <= '0;
      total      <= '0;
      prev_end   <= '0;
      scan_on    <= 1'b0;
      scan_addr  <= '0;
    end else begin
      if (result_v) begin
        total    <= total + added;
        result_v <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == {ADDR_W{1'b1}}) begin
            state <= pending ? S_PREP : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            lo        <= lo_c;
            hi        <= hi_c;
            need      <= duration;
            prev_end  <= end_slot;
            order_err <= !new_set && (end_slot < prev_end);
            if (new_set) begin
              total    <= '0;
              pending  <= 1'b1;
              clr_addr <= '0;
              state    <= S_CLEAR;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          pending <= 1'b0;
          have    <= '0;
          added   <= '0;
          if (empty_win) begin
            state <= S_CALC;
          end else begin
            scan_addr <= lo_word;
            scan_on   <= 1'b1;
            state     <= S_COUNT;
          end
        end
        S_COUNT: begin
          if (scan_on) begin
            if (scan_addr == hi_word) begin
              scan_on <= 1'b0;
            end else begin
              scan_addr <= scan_addr + ADDR_W'(1);
            end
          end
          if (dv) begin
            have <= have_next;
            if (dw == hi_word) begin
              state <= S_CALC;
            end
          end
        end
        S_CALC: begin
          rem <= rem_calc;
          if ((rem_calc == '0) || empty_win) begin
            short_flag <= rem_calc != '0;
            result_v   <= 1'b1;
            state      <= S_IDLE;
          end else begin
            scan_addr <= hi_word;
            scan_on   <= 1'b1;
            state     <= S_FILL;
          end
        end
        S_FILL: begin
          if (scan_on) begin
            if (scan_addr == lo_word) begin
              scan_on <= 1'b0;
            end else begin
              scan_addr <= scan_addr - ADDR_W'(1);
            end
          end
          if (dv) begin
            if (word_fits) begin
              rem   <= rem_after;
              added <= added + DUR_W'(free_cnt);
              if ((rem_after == '0) || (dw == lo_word)) begin
                short_flag <= rem_after != '0;
                result_v   <= 1'b1;
                scan_on    <= 1'b0;
                state      <= S_IDLE;
              end
            end else begin
              // More free slots than needed: pick the top ones bit by bit.
              bw_data <= rdata;
              bw_free <= free_bits;
              bw_addr <= dw;
              bit_idx <= BIT_W'(WORD_BITS - 1);
              scan_on <= 1'b0;
              state   <= S_BITS;
            end
          end
        end
        S_BITS: begin
          bw_data <= bw_data_next;
          bit_idx <= bit_idx - BIT_W'(1);
          if (bit_take) begin
            rem   <= rem - DUR_W'(1);
            added <= added + DUR_W'(1);
          end
          if (bits_finish) begin
            short_flag <= 1'b0;
            result_v   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  assign done          = result_v;
  assign slots_added   = added;
  assign total_running = total + added;
  assign order_error   = order_err;
  assign window_short  = short_flag;

endmodule
